/* hw/rtl/dlts_pkg.sv */
`default_nettype none

package dlts_pkg;

  // command codes as seen on the action field
  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_TICK = 2'd1,
    OP_DISP = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  // status codes of a result beat
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // depth of the command queue between front and back
  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  task_id;
    logic [15:0] first_delay;
    logic [15:0] repeat_period;
  } cmd_t;

  typedef struct packed {
    logic       fired;
    logic [7:0] fired_task;
    logic [1:0] status;
  } rsp_t;

  // classified command as it sits in the queue
  typedef struct packed {
    op_e         op;
    logic [7:0]  id;
    logic [15:0] dly;
    logic [15:0] per;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

`default_nettype wire

/* hw/rtl/dlts_ram.sv */
`default_nettype none

module dlts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/dlts_cmd_fifo.sv */
`default_nettype none

module dlts_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire dlts_pkg::qitem_t push_item_i,
  input  wire logic            pop_i,
  output dlts_pkg::qitem_t     head_o,
  output dlts_pkg::qstat_t     stat_o
);
  import dlts_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  qitem_t        slot_q [QDEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] cnt_q;

  assign head_o       = slot_q[rptr_q];
  assign stat_o.full  = (cnt_q == CW'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dlts_front.sv */
`default_nettype none

module dlts_front (
  input  wire logic             start,
  input  wire dlts_pkg::cmd_t   cmd_i,
  input  wire dlts_pkg::qstat_t qstat_i,
  output logic                  busy,
  output logic                  push_o,
  output dlts_pkg::qitem_t      item_o
);
  import dlts_pkg::*;

  assign busy   = qstat_i.full;
  assign push_o = start && !qstat_i.full;

  always_comb begin
    item_o.id  = cmd_i.task_id;
    item_o.dly = cmd_i.first_delay;
    item_o.per = cmd_i.repeat_period;
    unique case (cmd_i.action)
      OP_ADD:  item_o.op = OP_ADD;
      OP_TICK: item_o.op = OP_TICK;
      OP_DISP: item_o.op = OP_DISP;
      default: item_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/dlts_back.sv */
`default_nettype none

module dlts_back #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire dlts_pkg::qitem_t item_i,
  input  wire dlts_pkg::qstat_t qstat_i,
  output logic                  pop_o,
  output logic                  done_o,
  output dlts_pkg::rsp_t        rsp_o
);
  import dlts_pkg::*;

  localparam int unsigned TB = TIME_BITS;
  localparam int unsigned AW = $clog2(MAX_TASKS);
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam int unsigned EW = 2 * TB + 8;

  typedef struct packed {
    logic [TB-1:0] dly;
    logic [TB-1:0] per;
    logic [7:0]    id;
  } ent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_TICK_RD, S_DISP_RD, S_REM_RD, S_REM_WR,
    S_WALK_RD, S_WALK_CMP, S_SH_RD, S_SH_WR, S_WR_NEW
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q, idx_q, pos_q;
  logic [TB-1:0] before_q, rel_q;
  logic [TB-1:0] ins_dly_q, ins_per_q;
  logic [7:0]    ins_id_q;
  logic          done_q, done_d;
  rsp_t          rsp_q, rsp_d;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  ent_t          wdata, rdata;
  logic [EW-1:0] rdata_raw;
  logic [TB:0]   here;

  assign rdata  = ent_t'(rdata_raw);
  assign here   = {1'b0, before_q} + {1'b0, rdata.dly};
  assign pop_o  = (state_q == S_IDLE) && !qstat_i.empty;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // memory port control per state
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = rdata;
    raddr = '0;
    unique case (state_q)
      S_TICK_RD: begin
        we        = (rdata.dly != '0);
        wdata.dly = rdata.dly - 1'b1;
      end
      S_REM_RD:  raddr = idx_q[AW-1:0];
      S_REM_WR: begin
        we    = 1'b1;
        waddr = AW'(idx_q - 1'b1);
      end
      S_WALK_RD: raddr = idx_q[AW-1:0];
      S_SH_RD:   raddr = AW'(idx_q - 1'b1);
      S_SH_WR: begin
        we    = 1'b1;
        waddr = idx_q[AW-1:0];
        if (idx_q == pos_q + 1'b1) begin
          wdata.dly = rdata.dly - rel_q;
        end
      end
      S_WR_NEW: begin
        we    = 1'b1;
        waddr = pos_q[AW-1:0];
        wdata = '{dly: rel_q, per: ins_per_q, id: ins_id_q};
      end
      default: ;
    endcase
  end

  // result beat for the next cycle
  always_comb begin
    done_d = 1'b0;
    rsp_d  = rsp_q;
    unique case (state_q)
      S_IDLE: begin
        if (!qstat_i.empty) begin
          done_d = 1'b1;
          rsp_d  = '{fired: 1'b0, fired_task: 8'd0, status: ST_OK};
          unique case (item_i.op)
            OP_ADD: begin
              if (cnt_q == CW'(MAX_TASKS)) begin
                rsp_d.status = ST_FULL;
              end
            end
            OP_DISP: begin
              if (cnt_q == '0) begin
                rsp_d.status = ST_EMPTY;
              end else begin
                done_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DISP_RD: begin
        done_d = 1'b1;
        rsp_d  = '{fired: 1'b0, fired_task: 8'd0, status: ST_OK};
        if (rdata.dly == '0) begin
          rsp_d.fired      = 1'b1;
          rsp_d.fired_task = rdata.id;
        end
      end
      default: ;
    endcase
  end

  dlts_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_TASKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata_raw)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      pos_q     <= '0;
      before_q  <= '0;
      rel_q     <= '0;
      ins_dly_q <= '0;
      ins_per_q <= '0;
      ins_id_q  <= '0;
      done_q    <= 1'b0;
      rsp_q     <= '0;
    end else begin
      done_q <= done_d;
      rsp_q  <= rsp_d;
      unique case (state_q)
        S_IDLE: begin
          if (!qstat_i.empty) begin
            unique case (item_i.op)
              OP_ADD: begin
                if (cnt_q != CW'(MAX_TASKS)) begin
                  ins_id_q  <= item_i.id;
                  ins_dly_q <= TB'(item_i.dly);
                  ins_per_q <= TB'(item_i.per);
                  idx_q     <= '0;
                  before_q  <= '0;
                  state_q   <= S_WALK_RD;
                end
              end
              OP_TICK: begin
                if (cnt_q != '0) begin
                  state_q <= S_TICK_RD;
                end
              end
              OP_DISP: begin
                if (cnt_q != '0) begin
                  state_q <= S_DISP_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_TICK_RD: state_q <= S_IDLE;
        S_DISP_RD: begin
          if (rdata.dly != '0) begin
            state_q <= S_IDLE;
          end else begin
            ins_id_q  <= rdata.id;
            ins_dly_q <= rdata.per;
            ins_per_q <= rdata.per;
            before_q  <= '0;
            if (cnt_q > CW'(1)) begin
              idx_q   <= CW'(1);
              state_q <= S_REM_RD;
            end else begin
              idx_q   <= '0;
              cnt_q   <= cnt_q - 1'b1;
              state_q <= (rdata.per != '0) ? S_WALK_RD : S_IDLE;
            end
          end
        end
        S_REM_RD: state_q <= S_REM_WR;
        S_REM_WR: begin
          if (idx_q + 1'b1 == cnt_q) begin
            cnt_q   <= cnt_q - 1'b1;
            idx_q   <= '0;
            state_q <= (ins_per_q != '0) ? S_WALK_RD : S_IDLE;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_REM_RD;
          end
        end
        S_WALK_RD: begin
          if (idx_q == cnt_q) begin
            pos_q   <= cnt_q;
            rel_q   <= ins_dly_q - before_q;
            state_q <= S_SH_RD;
          end else begin
            state_q <= S_WALK_CMP;
          end
        end
        S_WALK_CMP: begin
          // insert before the first entry due strictly later
          if (here > {1'b0, ins_dly_q}) begin
            pos_q   <= idx_q;
            rel_q   <= ins_dly_q - before_q;
            idx_q   <= cnt_q;
            state_q <= S_SH_RD;
          end else begin
            before_q <= here[TB-1:0];
            idx_q    <= idx_q + 1'b1;
            state_q  <= S_WALK_RD;
          end
        end
        S_SH_RD: begin
          state_q <= (idx_q == pos_q) ? S_WR_NEW : S_SH_WR;
        end
        S_SH_WR: begin
          idx_q   <= idx_q - 1'b1;
          state_q <= S_SH_RD;
        end
        S_WR_NEW: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/delta_list_task_scheduler.sv */
`default_nettype none

// channel   direction  handshake                      payload
// command   in         start high, busy low           cmd_i  (action, id, delay, period)
// result    out        done_o strobe, one cycle       rsp_o  (fired, fired_task, status)
//
// a no-op or a rejected command is finished in S_IDLE of the back end; a tick
// visits S_TICK_RD and a dispatch that finds the head not due visits S_DISP_RD
// an add walks the list (S_WALK_RD and S_WALK_CMP per entry passed) and shifts
// the tail (S_SH_RD and S_SH_WR per entry moved), then writes the new entry;
// a dispatch that fires also shifts the list down by one (S_REM_RD and S_REM_WR
// per entry) and re-adds a periodic task; every step goes through the single
// ram port pair
// reset empties the list; entries are not cleared, the count guards them
// busy rises while the two-beat command queue is full; results cannot stall

module delta_list_task_scheduler #(
  parameter int unsigned MAX_TASKS = 16,
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire dlts_pkg::cmd_t cmd_i,
  output logic                done_o,
  output dlts_pkg::rsp_t      rsp_o
);
  import dlts_pkg::*;

  qitem_t push_item, head_item;
  qstat_t qstat;
  logic   push, pop;

  // front: accept and classify command beats
  dlts_front u_front (
    .start  (start),
    .cmd_i  (cmd_i),
    .qstat_i(qstat),
    .busy   (busy),
    .push_o (push),
    .item_o (push_item)
  );

  // short queue decoupling accept from execution
  dlts_cmd_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .pop_i      (pop),
    .head_o     (head_item),
    .stat_o     (qstat)
  );

  // back: delta list engine over the entry ram
  dlts_back #(
    .MAX_TASKS(MAX_TASKS),
    .TIME_BITS(TIME_BITS)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (head_item),
    .qstat_i(qstat),
    .pop_o  (pop),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

/* hw/rtl/dlts_checker.sv */
`default_nettype none

module dlts_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           start,
  input wire logic           busy,
  input wire logic           done_o,
  input wire dlts_pkg::rsp_t rsp_o
);
  import dlts_pkg::*;

  // a fired beat always reports ok
  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.fired |-> rsp_o.status == ST_OK)
    else $error("fired with error status");

  // no task id without a firing
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !rsp_o.fired |-> rsp_o.fired_task == 8'd0)
    else $error("task id on non-fired beat");

  // status code stays in range
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_FULL ||
                rsp_o.status == ST_EMPTY))
    else $error("bad status code");

  // a full-list status never comes with a firing
  a_full_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_FULL |-> !rsp_o.fired)
    else $error("full status on a firing");

  // the command queue only fills through an offered beat
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a command");

endmodule

bind delta_list_task_scheduler dlts_checker u_chk (.*);

`default_nettype wire
